FILE: hw/rtl/sct_pkg.sv
// Shared types and constants for the sphere contact test pipeline.
package sct_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 33;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 31;
  localparam int NUM_W   = 47;
  localparam int QUO_W   = 15;
  localparam int NORM_W  = 16;
  localparam int AXES    = 3;
  localparam logic [QUO_W-1:0] NORM_ONE = 15'd16384;

  typedef struct packed {
    logic                                 hit;
    logic                                 mode;
    logic [AXES-1:0]                      neg;
    logic [AXES-1:0][MAG_W-1:0]           mag;
    logic [RAD_W-1:0]                     radius;
    logic [COORD_W-1:0]                   dbase;
    logic [AXES-1:0][COORD_W-1:0]         ibase;
  } sq_side_t;

  typedef struct packed {
    logic                                 hit;
    logic                                 mode;
    logic                                 zero_len;
    logic [AXES-1:0]                      neg;
    logic [RAD_W-1:0]                     radius;
    logic [COORD_W-1:0]                   depth;
    logic [AXES-1:0][COORD_W-1:0]         ibase;
  } dv_side_t;

endpackage

FILE: hw/rtl/sct_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
module sct_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ce,
  input  logic                       in_valid,
  input  logic [63:0]                in_x,
  input  sct_pkg::sq_side_t          in_side,
  output logic                       out_valid,
  output logic [sct_pkg::ROOT_W-1:0] out_root,
  output sct_pkg::sq_side_t          out_side
);

  localparam int STAGES = sct_pkg::ROOT_W;

  logic                       v_r    [STAGES];
  logic [63:0]                x_r    [STAGES];
  logic [34:0]                rem_r  [STAGES];
  logic [sct_pkg::ROOT_W-1:0] root_r [STAGES];
  sct_pkg::sq_side_t          side_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                       v_in;
    logic [63:0]                x_in;
    logic [34:0]                rem_in;
    logic [sct_pkg::ROOT_W-1:0] root_in;
    sct_pkg::sq_side_t          side_in;
    logic [34:0]                remn;
    logic [34:0]                trial;
    logic                       ge;
    logic [34:0]                rem_nxt;
    logic [sct_pkg::ROOT_W-1:0] root_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign x_in    = in_x;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign x_in    = x_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign remn     = {rem_in[32:0], x_in[63-2*k -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};
    assign ge       = (remn >= trial);
    assign rem_nxt  = ge ? (remn - trial) : remn;
    assign root_nxt = {root_in[sct_pkg::ROOT_W-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_in;
      end
      if (ce) begin
        x_r[k]    <= x_in;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_root  = root_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

FILE: hw/rtl/sct_ndiv.sv
// Pipelined three-lane restoring divider for the normal components.
module sct_ndiv (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           ce,
  input  logic                                           in_valid,
  input  logic [sct_pkg::AXES-1:0][sct_pkg::NUM_W-1:0]   in_num,
  input  logic [sct_pkg::ROOT_W-1:0]                     in_den,
  input  sct_pkg::dv_side_t                              in_side,
  output logic                                           out_valid,
  output logic [sct_pkg::AXES-1:0][sct_pkg::QUO_W-1:0]   out_quo,
  output sct_pkg::dv_side_t                              out_side
);

  localparam int STAGES = sct_pkg::QUO_W;

  logic                                         v_r    [STAGES];
  logic [sct_pkg::AXES-1:0][sct_pkg::NUM_W-1:0] rem_r  [STAGES];
  logic [sct_pkg::AXES-1:0][sct_pkg::QUO_W-1:0] quo_r  [STAGES];
  logic [sct_pkg::ROOT_W-1:0]                   den_r  [STAGES];
  sct_pkg::dv_side_t                            side_r [STAGES];

  for (genvar k = 0; k < STAGES; k++) begin : g_stage
    logic                                         v_in;
    logic [sct_pkg::AXES-1:0][sct_pkg::NUM_W-1:0] rem_in;
    logic [sct_pkg::AXES-1:0][sct_pkg::QUO_W-1:0] quo_in;
    logic [sct_pkg::ROOT_W-1:0]                   den_in;
    sct_pkg::dv_side_t                            side_in;
    logic [sct_pkg::NUM_W-1:0]                    dsh;
    logic [sct_pkg::AXES-1:0][sct_pkg::NUM_W-1:0] rem_nxt;
    logic [sct_pkg::AXES-1:0][sct_pkg::QUO_W-1:0] quo_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_valid;
      assign rem_in  = in_num;
      assign quo_in  = '0;
      assign den_in  = in_den;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign quo_in  = quo_r[k-1];
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign dsh = {{(sct_pkg::NUM_W-sct_pkg::ROOT_W){1'b0}}, den_in} << (STAGES-1-k);

    always_comb begin
      for (int i = 0; i < sct_pkg::AXES; i++) begin
        if (rem_in[i] >= dsh) begin
          rem_nxt[i] = rem_in[i] - dsh;
          quo_nxt[i] = {quo_in[i][sct_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt[i] = rem_in[i];
          quo_nxt[i] = {quo_in[i][sct_pkg::QUO_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ce) begin
        v_r[k] <= v_in;
      end
      if (ce) begin
        rem_r[k]  <= rem_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_quo   = quo_r[STAGES-1];
  assign out_side  = side_r[STAGES-1];

endmodule

FILE: hw/rtl/sphere_contact_test_core.sv
// Sphere against sphere or axis-aligned box contact test, fully pipelined.
// One transaction per cycle enters and leaves unless stalled; the stages are an input register,
// four stages for offsets, squares and the hit compare, 32 stages of square root,
// one stage for the normal numerators, 15 divider stages, one multiply stage and the
// output register. The whole pipeline advances whenever the output register is empty
// or its transaction is being taken, so a stall holds every stage in place.
module sphere_contact_test_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // center_x, center_y, center_z, radius, other_a_x, other_a_y, other_a_z,
  // other_b_x, other_b_y, other_b_z, one pad bit
  input  logic [319:0] in_tdata,
  // mode
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // impact_x, impact_y, impact_z, normal_x, normal_y, normal_z, depth
  output logic [175:0] out_tdata,
  // hit
  output logic         out_tuser
);

  localparam int AX = sct_pkg::AXES;
  localparam int CW = sct_pkg::COORD_W;
  localparam int MW = sct_pkg::MAG_W;

  logic ce;
  logic out_valid_r;

  assign ce        = !out_valid_r || out_tready;
  assign in_tready = ce;

  // Stage 0: input register.
  logic         v0_r;
  logic         mode0_r;
  logic [318:0] data0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (ce) begin
      v0_r <= in_tvalid;
    end
    if (ce) begin
      mode0_r <= in_tuser;
      data0_r <= in_tdata[318:0];
    end
  end

  // Stage 1: offsets, clamp, magnitudes.
  logic [AX-1:0][CW-1:0] c_w, a_w, b_w;
  logic [sct_pkg::RAD_W-1:0] rad_w;
  logic [CW-1:0] rs_w;
  logic [AX-1:0]         neg_nxt;
  logic [AX-1:0][MW-1:0] mag_nxt;
  logic [AX-1:0][CW-1:0] ibase_nxt;

  assign c_w[0] = data0_r[31:0];
  assign c_w[1] = data0_r[63:32];
  assign c_w[2] = data0_r[95:64];
  assign rad_w  = data0_r[126:96];
  assign a_w[0] = data0_r[158:127];
  assign a_w[1] = data0_r[190:159];
  assign a_w[2] = data0_r[222:191];
  assign b_w[0] = data0_r[254:223];
  assign b_w[1] = data0_r[286:255];
  assign b_w[2] = data0_r[318:287];

  assign rs_w = {1'b0, rad_w} + (b_w[0][CW-1] ? '0 : {1'b0, b_w[0][CW-2:0]});

  always_comb begin
    logic [CW-1:0] t;
    logic [CW-1:0] cl;
    logic [CW-1:0] oth;
    logic [MW-1:0] d;
    for (int i = 0; i < AX; i++) begin
      t   = ($signed(c_w[i]) < $signed(b_w[i])) ? c_w[i] : b_w[i];
      cl  = ($signed(a_w[i]) > $signed(t)) ? a_w[i] : t;
      oth = mode0_r ? cl : a_w[i];
      d   = {c_w[i][CW-1], c_w[i]} - {oth[CW-1], oth};
      neg_nxt[i]   = d[MW-1];
      mag_nxt[i]   = d[MW-1] ? (~d + 1'b1) : d;
      ibase_nxt[i] = mode0_r ? cl : c_w[i];
    end
  end

  logic                      v1_r, mode1_r;
  logic [AX-1:0]             neg1_r;
  logic [AX-1:0][MW-1:0]     mag1_r;
  logic [sct_pkg::RAD_W-1:0] rad1_r;
  logic [CW-1:0]             dbase1_r;
  logic [AX-1:0][CW-1:0]     ibase1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= v0_r;
    end
    if (ce) begin
      mode1_r  <= mode0_r;
      neg1_r   <= neg_nxt;
      mag1_r   <= mag_nxt;
      rad1_r   <= rad_w;
      dbase1_r <= mode0_r ? {1'b0, rad_w} : rs_w;
      ibase1_r <= ibase_nxt;
    end
  end

  // Stage 2: partial products of the squares and the squared limit.
  logic                      v2_r, mode2_r;
  logic [AX-1:0]             neg2_r;
  logic [AX-1:0][MW-1:0]     mag2_r;
  logic [sct_pkg::RAD_W-1:0] rad2_r;
  logic [CW-1:0]             dbase2_r;
  logic [AX-1:0][CW-1:0]     ibase2_r;
  logic [AX-1:0][33:0]       hh2_r;
  logic [AX-1:0][32:0]       hl2_r;
  logic [AX-1:0][31:0]       ll2_r;
  logic [63:0]               lim2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (ce) begin
      v2_r <= v1_r;
    end
    if (ce) begin
      mode2_r  <= mode1_r;
      neg2_r   <= neg1_r;
      mag2_r   <= mag1_r;
      rad2_r   <= rad1_r;
      dbase2_r <= dbase1_r;
      ibase2_r <= ibase1_r;
      lim2_r   <= 64'(dbase1_r) * 64'(dbase1_r);
      for (int i = 0; i < AX; i++) begin
        hh2_r[i] <= 34'(mag1_r[i][32:16]) * 34'(mag1_r[i][32:16]);
        hl2_r[i] <= 33'(mag1_r[i][32:16]) * 33'(mag1_r[i][15:0]);
        ll2_r[i] <= 32'(mag1_r[i][15:0]) * 32'(mag1_r[i][15:0]);
      end
    end
  end

  // Stage 3: full squares.
  logic                      v3_r, mode3_r;
  logic [AX-1:0]             neg3_r;
  logic [AX-1:0][MW-1:0]     mag3_r;
  logic [sct_pkg::RAD_W-1:0] rad3_r;
  logic [CW-1:0]             dbase3_r;
  logic [AX-1:0][CW-1:0]     ibase3_r;
  logic [AX-1:0][65:0]       sq3_r;
  logic [63:0]               lim3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (ce) begin
      v3_r <= v2_r;
    end
    if (ce) begin
      mode3_r  <= mode2_r;
      neg3_r   <= neg2_r;
      mag3_r   <= mag2_r;
      rad3_r   <= rad2_r;
      dbase3_r <= dbase2_r;
      ibase3_r <= ibase2_r;
      lim3_r   <= lim2_r;
      for (int i = 0; i < AX; i++) begin
        sq3_r[i] <= {hh2_r[i], 32'b0} + {16'b0, hl2_r[i], 17'b0} + {34'b0, ll2_r[i]};
      end
    end
  end

  // Stage 4: sum of squares and the hit compare.
  logic [66:0]       tot_w;
  logic              v4_r;
  logic [63:0]       x4_r;
  sct_pkg::sq_side_t side4_r;

  assign tot_w = {1'b0, sq3_r[0]} + {1'b0, sq3_r[1]} + {1'b0, sq3_r[2]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (ce) begin
      v4_r <= v3_r;
    end
    if (ce) begin
      x4_r           <= tot_w[63:0];
      side4_r.hit    <= (tot_w <= {3'b0, lim3_r});
      side4_r.mode   <= mode3_r;
      side4_r.neg    <= neg3_r;
      side4_r.mag    <= mag3_r;
      side4_r.radius <= rad3_r;
      side4_r.dbase  <= dbase3_r;
      side4_r.ibase  <= ibase3_r;
    end
  end

  // Square root.
  logic                       sq_valid;
  logic [sct_pkg::ROOT_W-1:0] sq_root;
  sct_pkg::sq_side_t          sq_side;

  sct_isqrt u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v4_r),
    .in_x      (x4_r),
    .in_side   (side4_r),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Stage 5: divider numerators and depth.
  logic                                    v5_r;
  logic [AX-1:0][sct_pkg::NUM_W-1:0]       num5_r;
  logic [sct_pkg::ROOT_W-1:0]              len5_r;
  sct_pkg::dv_side_t                       side5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (ce) begin
      v5_r <= sq_valid;
    end
    if (ce) begin
      len5_r           <= sq_root;
      side5_r.hit      <= sq_side.hit;
      side5_r.mode     <= sq_side.mode;
      side5_r.zero_len <= (sq_root == '0);
      side5_r.neg      <= sq_side.neg;
      side5_r.radius   <= sq_side.radius;
      side5_r.depth    <= sq_side.dbase - sq_root;
      side5_r.ibase    <= sq_side.ibase;
      for (int i = 0; i < AX; i++) begin
        num5_r[i] <= {sq_side.mag[i], 14'b0} + {16'b0, sq_root[sct_pkg::ROOT_W-1:1]};
      end
    end
  end

  // Normal division.
  logic                                    dv_valid;
  logic [AX-1:0][sct_pkg::QUO_W-1:0]       dv_quo;
  sct_pkg::dv_side_t                       dv_side;

  sct_ndiv u_ndiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v5_r),
    .in_num    (num5_r),
    .in_den    (len5_r),
    .in_side   (side5_r),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_side  (dv_side)
  );

  // Stage 6: clamp and sign the normal, scale it by the radius.
  logic [AX-1:0][sct_pkg::QUO_W-1:0]  qc_w;
  logic                               v6_r;
  logic [AX-1:0][sct_pkg::NORM_W-1:0] n6_r;
  logic [AX-1:0][45:0]                prod6_r;
  sct_pkg::dv_side_t                  side6_r;

  always_comb begin
    for (int i = 0; i < AX; i++) begin
      if (dv_side.zero_len) begin
        qc_w[i] = '0;
      end else if (dv_quo[i] > sct_pkg::NORM_ONE) begin
        qc_w[i] = sct_pkg::NORM_ONE;
      end else begin
        qc_w[i] = dv_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
    end else if (ce) begin
      v6_r <= dv_valid;
    end
    if (ce) begin
      side6_r <= dv_side;
      for (int i = 0; i < AX; i++) begin
        n6_r[i]    <= dv_side.neg[i] ? (~{1'b0, qc_w[i]} + 1'b1) : {1'b0, qc_w[i]};
        prod6_r[i] <= 46'(qc_w[i]) * 46'(dv_side.radius);
      end
    end
  end

  // Stage 7: impact point and output register.
  logic [AX-1:0][CW-1:0] imp_w;

  always_comb begin
    logic [46:0] pr;
    logic [34:0] s;
    logic [34:0] pe;
    for (int i = 0; i < AX; i++) begin
      pr = {1'b0, prod6_r[i]} + 47'd8192;
      pe = {2'b0, pr[46:14]};
      s  = {{3{side6_r.ibase[i][CW-1]}}, side6_r.ibase[i]} +
           (side6_r.neg[i] ? (~pe + 1'b1) : pe);
      if (side6_r.mode) begin
        imp_w[i] = side6_r.ibase[i];
      end else if (s[34] && (s[33:31] != 3'b111)) begin
        imp_w[i] = {1'b1, {(CW-1){1'b0}}};
      end else if (!s[34] && (s[33:31] != 3'b000)) begin
        imp_w[i] = {1'b0, {(CW-1){1'b1}}};
      end else begin
        imp_w[i] = s[CW-1:0];
      end
    end
  end

  logic [175:0] data7_r;
  logic         hit7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ce) begin
      out_valid_r <= v6_r;
    end
    if (ce) begin
      hit7_r <= side6_r.hit;
      if (side6_r.hit) begin
        data7_r <= {side6_r.depth, n6_r[2], n6_r[1], n6_r[0], imp_w[2], imp_w[1], imp_w[0]};
      end else begin
        data7_r <= '0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = data7_r;
  assign out_tuser  = hit7_r;

endmodule

FILE: tb/sphere_contact_test_core_test.sv
// Self-checking testbench for the sphere contact test core with its own contact predictor.
module sphere_contact_test_core_test;

  localparam int AXES           = sct_pkg::AXES;
  localparam int RAD_W          = sct_pkg::RAD_W;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 80;

  typedef enum logic {MODE_SPHERE = 1'b0, MODE_BOX = 1'b1} contact_mode_e;

  typedef struct packed {
    logic                      mode;
    logic [AXES-1:0][31:0]     center;
    logic [RAD_W-1:0]          radius;
    logic [AXES-1:0][31:0]     lo_pt;
    logic [AXES-1:0][31:0]     hi_pt;
  } shape_pair_t;

  typedef struct packed {
    logic                      hit;
    logic [AXES-1:0][31:0]     impact;
    logic [AXES-1:0][15:0]     normal;
    logic [31:0]               depth;
  } contact_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [319:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [175:0] out_tdata;
  logic         out_tuser;

  contact_t expected_contacts[$];
  int       mismatch_count;
  int       idle_cycles;
  int       send_idle_pct;
  int       recv_idle_pct;

  sphere_contact_test_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] abs_of(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint unit_component(longint d, logic [63:0] len);
    logic [63:0] q;
    if (len == 0) return 0;
    q = ((abs_of(d) << 14) + (len >> 1)) / len;
    if (q > 64'd16384) q = 64'd16384;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic contact_t predict_contact(shape_pair_t p);
    contact_t    res;
    longint      cc[3];
    longint      aa[3];
    longint      bb[3];
    longint      off[3];
    longint      pt[3];
    longint      nrm[3];
    longint      ro;
    longint      sv;
    logic [66:0] sum;
    logic [63:0] rs;
    logic [63:0] len;
    logic [63:0] pm;
    logic [63:0] m;
    res = '0;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      cc[i] = longint'($signed(p.center[i]));
      aa[i] = longint'($signed(p.lo_pt[i]));
      bb[i] = longint'($signed(p.hi_pt[i]));
    end
    if (p.mode == MODE_SPHERE) begin
      ro = (bb[0] < 0) ? 0 : bb[0];
      rs = 64'(p.radius) + 64'(ro);
      for (int i = 0; i < 3; i++) off[i] = cc[i] - aa[i];
    end else begin
      rs = 64'(p.radius);
      for (int i = 0; i < 3; i++) begin
        pt[i] = (cc[i] < bb[i]) ? cc[i] : bb[i];
        pt[i] = (aa[i] > pt[i]) ? aa[i] : pt[i];
        off[i] = cc[i] - pt[i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      m = abs_of(off[i]);
      sum = sum + 67'(m) * 67'(m);
    end
    if (sum > 67'(rs * rs)) return res;
    len = int_sqrt(sum[63:0]);
    res.hit = 1'b1;
    res.depth = 32'(rs - len);
    for (int i = 0; i < 3; i++) begin
      nrm[i] = unit_component(off[i], len);
      res.normal[i] = 16'(nrm[i]);
      if (p.mode == MODE_SPHERE) begin
        pm = (abs_of(nrm[i]) * 64'(p.radius) + 64'd8192) >> 14;
        sv = cc[i] + ((nrm[i] < 0) ? -longint'(pm) : longint'(pm));
        if (sv > 64'sd2147483647) sv = 64'sd2147483647;
        if (sv < -64'sd2147483648) sv = -64'sd2147483648;
        res.impact[i] = 32'(sv);
      end else begin
        res.impact[i] = 32'(pt[i]);
      end
    end
    return res;
  endfunction

  task automatic send_pair(shape_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = p.mode;
    in_tdata  = {1'b0, p.hi_pt[2], p.hi_pt[1], p.hi_pt[0], p.lo_pt[2], p.lo_pt[1],
                 p.lo_pt[0], p.radius, p.center[2], p.center[1], p.center[0]};
    do @(posedge clk); while (!in_tready);
    expected_contacts.push_back(predict_contact(p));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic shape_pair_t make_pair(contact_mode_e mode, longint cx, longint cy,
                                            longint cz, longint r, longint ax, longint ay,
                                            longint az, longint bx, longint by, longint bz);
    shape_pair_t p;
    p.mode = mode;
    p.center = {32'(cz), 32'(cy), 32'(cx)};
    p.radius = RAD_W'(r);
    p.lo_pt = {32'(az), 32'(ay), 32'(ax)};
    p.hi_pt = {32'(bz), 32'(by), 32'(bx)};
    return p;
  endfunction

  function automatic shape_pair_t random_pair();
    shape_pair_t p;
    longint      span;
    int          kind;
    kind = $urandom_range(9);
    p.mode = 1'($urandom_range(1));
    p.center = {$urandom, $urandom, $urandom};
    p.radius = RAD_W'($urandom);
    p.lo_pt = {$urandom, $urandom, $urandom};
    p.hi_pt = {$urandom, $urandom, $urandom};
    if (kind >= 2) begin
      span = longint'(1) << $urandom_range(4, 30);
      p.radius = RAD_W'($urandom_range(0, 32'(span)));
      for (int i = 0; i < 3; i++) begin
        p.lo_pt[i] = p.center[i] + 32'($urandom_range(0, 32'(span)) - 32'(span / 2));
        if (p.mode == MODE_BOX)
          p.hi_pt[i] = p.lo_pt[i] + 32'($urandom_range(0, 32'(span)));
      end
      if (p.mode == MODE_SPHERE)
        p.hi_pt[0] = (kind == 9) ? $urandom : 32'($urandom_range(0, 32'(span)));
    end
    return p;
  endfunction

  task automatic test_sphere_cases();
    longint mx;
    longint mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_pair(make_pair(MODE_SPHERE, 0, 0, 0, 65536, 0, 0, 0, 65536, 0, 0));
    send_pair(make_pair(MODE_SPHERE, 0, 0, 0, 65536, 131072, 0, 0, 65536, 7, -9));
    send_pair(make_pair(MODE_SPHERE, 0, 0, 0, 65536, 131073, 0, 0, 65536, 0, 0));
    send_pair(make_pair(MODE_SPHERE, 100, 200, 300, 5000, 400, -100, 900, -77, mx, mn));
    send_pair(make_pair(MODE_SPHERE, mx, mx, mx, mx, mx - 1000, mx, mx, 500, 0, 0));
    send_pair(make_pair(MODE_SPHERE, mn, mn, mn, mx, mn + 1000, mn, mn, 0, 0, 0));
    send_pair(make_pair(MODE_SPHERE, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx));
    send_pair(make_pair(MODE_SPHERE, mn, 0, mx, 0, mn, 0, mx, 0, mn, mx));
    send_pair(make_pair(MODE_SPHERE, 1, -1, 3, 7, -2, 2, 0, mn, 0, 0));
    send_pair(make_pair(MODE_SPHERE, -5000, 3000, 0, 100000, -4000, 2000, 1000, 20, 0, 0));
  endtask

  task automatic test_box_cases();
    longint mx;
    longint mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_pair(make_pair(MODE_BOX, 0, 0, 0, 100, -10, -10, -10, 10, 10, 10));
    send_pair(make_pair(MODE_BOX, 200, 0, 0, 100, -100, -10, -10, 100, 10, 10));
    send_pair(make_pair(MODE_BOX, 201, 0, 0, 100, -100, -10, -10, 100, 10, 10));
    send_pair(make_pair(MODE_BOX, 50, 60, 70, 1000, 80, 10, 90, 20, 100, 30));
    send_pair(make_pair(MODE_BOX, mx, mx, mx, mx, mn, mn, mn, mx, mx, mx));
    send_pair(make_pair(MODE_BOX, mn, mn, mn, mx, mx, mx, mx, mx, mx, mx));
    send_pair(make_pair(MODE_BOX, mx, mn, mx, mx, mx - 5, mn, mx - 7, mx, mn + 3, mx));
    send_pair(make_pair(MODE_BOX, -300, 400, 0, 600, -100, -100, -100, 100, 100, 100));
    send_pair(make_pair(MODE_BOX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  task automatic test_random_stream(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pair(random_pair());
  endtask

  always @(negedge clk) begin
    if (rst_n) out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    contact_t got;
    contact_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.hit = out_tuser;
      got.impact = out_tdata[95:0];
      got.normal = out_tdata[143:96];
      got.depth = out_tdata[175:144];
      if (expected_contacts.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected transaction: %p", got);
      end else begin
        want = expected_contacts.pop_front();
        if (got.hit !== want.hit || got.impact !== want.impact ||
            got.normal !== want.normal || got.depth !== want.depth) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %p, actual %p", want, got);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    idle_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    out_tready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_sphere_cases();
    test_box_cases();
    test_random_stream(130, 30, 81);
    test_random_stream(130, 81, 30);
    test_random_stream(140, 0, 0);
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sphere_contact_test_core.f
hw/rtl/sct_pkg.sv
hw/rtl/sct_isqrt.sv
hw/rtl/sct_ndiv.sv
hw/rtl/sphere_contact_test_core.sv
tb/sphere_contact_test_core_test.sv
